>>> design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cfb_pkg.sv
package cfb_pkg;

   // frame layout
   localparam int unsigned FRAME_BYTES = 8;
   localparam int unsigned BODY_BYTES  = 6;
   localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

   // byte positions in the frame
   localparam logic [IDX_W-1:0] POS_ID     = 3'd0;
   localparam logic [IDX_W-1:0] POS_CMD    = 3'd1;
   localparam logic [IDX_W-1:0] POS_PARAM0 = 3'd2;
   localparam logic [IDX_W-1:0] POS_PARAM1 = 3'd3;
   localparam logic [IDX_W-1:0] POS_PARAM2 = 3'd4;
   localparam logic [IDX_W-1:0] POS_PARAM3 = 3'd5;
   localparam logic [IDX_W-1:0] POS_CRC_LO = 3'd6;
   localparam logic [IDX_W-1:0] POS_CRC_HI = 3'd7;

   // crc-16 seed
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  device_id;
      logic [7:0]  command_code;
      logic [31:0] command_param;
   } cmd_type;

   // one byte step of crc-16, polynomial 0x1021, msb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [7:0]  t;
      logic [15:0] r;
      t = acc[15:8] ^ b;
      t = t ^ (t >> 4);
      r = {acc[7:0], 8'h00} ^ {t[3:0], 12'h000} ^ {3'b000, t, 5'b00000} ^ {8'h00, t};
      return r;
   endfunction

endpackage

>>> design/cfb_front.sv
`include "assert_macros.svh"

module cfb_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  cfb_pkg::cmd_type req_cmd,
   output logic            q_valid,
   output cfb_pkg::cmd_type q_cmd,
   input  logic            q_take
);
   import cfb_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   // handshake and queue status
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_cmd;
      end
   end

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `ASSERT_IMPLIES(a_take_nonempty, clock, reset, q_take, q_valid, "take from empty queue")
   `ASSERT_NEXT(a_fill_stall, clock, reset, push && !pop && count_ff == QCNT_W'(QUEUE_DEPTH - 1), req_stall, "full queue not stalling")

endmodule

>>> design/cfb_back.sv
`include "assert_macros.svh"

module cfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cfb_pkg::cmd_type q_cmd,
   output logic             q_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_frame_last
);
   import cfb_pkg::*;

   cmd_type           cmd_ff, cmd_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_tx_byte_ff, rsp_tx_byte_in;
   logic              rsp_frame_last_ff, rsp_frame_last_in;
   logic              advance;
   logic              at_last;
   logic [7:0]        cur_byte;

   // output slot free and a byte to send
   assign advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last = (idx_ff == POS_CRC_HI);
   assign q_take  = q_valid && (!busy_ff || (advance && at_last));

   // frame byte select
   always_comb begin
      unique case (idx_ff)
         POS_ID:     cur_byte = cmd_ff.device_id;
         POS_CMD:    cur_byte = cmd_ff.command_code;
         POS_PARAM0: cur_byte = cmd_ff.command_param[7:0];
         POS_PARAM1: cur_byte = cmd_ff.command_param[15:8];
         POS_PARAM2: cur_byte = cmd_ff.command_param[23:16];
         POS_PARAM3: cur_byte = cmd_ff.command_param[31:24];
         POS_CRC_LO: cur_byte = crc_ff[7:0];
         POS_CRC_HI: cur_byte = crc_ff[15:8];
         default:    cur_byte = 8'h00;
      endcase
   end

   // sequencer: one frame byte per cycle unless rsp is stalled, crc folded in as the body goes out
   always_comb begin
      cmd_in  = cmd_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (advance) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff < IDX_W'(BODY_BYTES)) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_take) begin
         cmd_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = '0;
         crc_in  = CRC_INIT;
      end
   end

   // output register
   always_comb begin
      rsp_tx_byte_in    = rsp_tx_byte_ff;
      rsp_frame_last_in = rsp_frame_last_ff;
      if (advance) begin
         rsp_valid_in      = 1'b1;
         rsp_tx_byte_in    = cur_byte;
         rsp_frame_last_in = at_last;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      crc_ff            <= crc_in;
      rsp_tx_byte_ff    <= rsp_tx_byte_in;
      rsp_frame_last_ff <= rsp_frame_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_byte    = rsp_tx_byte_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // checks
   `ASSERT_IMPLIES(a_take_when_free, clock, reset, q_take, !busy_ff || (advance && at_last), "frame overrun")
   `ASSERT_NEXT(a_take_starts, clock, reset, q_take, busy_ff && idx_ff == '0 && crc_ff == CRC_INIT, "frame start lost")
   `ASSERT_NEXT(a_last_marked, clock, reset, advance && at_last, rsp_valid_ff && rsp_frame_last_ff, "last byte not marked")

endmodule

>>> design/command_frame_builder_crc16_unit.sv
// command frame builder with crc-16
// req channel: one word per command (device id, command code, 32-bit parameter),
//   taken when req_valid is high and req_stall is low.
// rsp channel: eight words per command, one byte each: id, command, parameter
//   low byte first, then crc-16 (poly 0x1021, seed 0xffff) low byte first;
//   rsp_frame_last marks the eighth byte.
// a two-entry command queue sits between the input side and the byte sequencer,
//   so a new command is taken while the previous frame is still going out.
// when the block is idle, the first byte of a frame goes out through the queue slot,
//   the sequencer command register and then the output register.
// output rate is set by the single byte-wide output register; frames follow each
//   other with no gap.
// stall on rsp holds the current byte and the sequencer; the queue then fills
//   and req_stall rises once both entries are taken.
// reset (synchronous, active high) empties the queue and drops any frame in
//   progress; no clearing pass is needed.
module command_frame_builder_crc16_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_device_id,
   input  logic [7:0]  req_command_code,
   input  logic [31:0] req_command_param,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_frame_last
);
   import cfb_pkg::*;

   cmd_type req_cmd;
   cmd_type q_cmd;
   logic    q_valid;
   logic    q_take;

   // pack the command word
   assign req_cmd.device_id     = req_device_id;
   assign req_cmd.command_code  = req_command_code;
   assign req_cmd.command_param = req_command_param;

   // input side and command queue
   cfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_take    (q_take)
   );

   // byte sequencer with crc
   cfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_take         (q_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
